[src/ksb_pkg.sv]
// Shared constants, types and bit-serial helper functions for the kinetic
// scroll bounce step block. Used by ksb_serial_mul and kinetic_scroll_bounce_step.
// No dependencies.
package ksb_pkg;

    // Fixed-point format and working widths.
    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = 32;
    localparam int GAIN_W     = 17;
    localparam int WORK_W     = POS_W + 2;
    localparam int CNT_W      = $clog2(WORK_W);
    localparam int POS_IDX_W  = $clog2(POS_W);
    localparam int MUL_CYCLES = FRAC_BITS + WORK_W;
    localparam int MUL_CNT_W  = $clog2(MUL_CYCLES);
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HARD_LOW        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_LOW        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_HIGH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_HIGH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_DECAY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSHOOT_DECAY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_GAIN     = 3'd6;

    // Register values after reset.
    localparam logic signed [POS_W-1:0] HARD_LOW_RST  = -32'sd1310720;
    localparam logic signed [POS_W-1:0] SOFT_LOW_RST  = 32'sd0;
    localparam logic signed [POS_W-1:0] SOFT_HIGH_RST = 32'sd65536000;
    localparam logic signed [POS_W-1:0] HARD_HIGH_RST = 32'sd66846720;
    localparam logic [GAIN_W-1:0]       NORMAL_DECAY_RST    = 17'd58982;
    localparam logic [GAIN_W-1:0]       OVERSHOOT_DECAY_RST = 17'd45875;
    localparam logic [GAIN_W-1:0]       BOUNCE_GAIN_RST     = 17'd19661;

    localparam logic signed [POS_W-1:0] ONE_VAL     = POS_W'(1) << FRAC_BITS;
    localparam logic signed [POS_W-1:0] NEG_ONE_VAL = -ONE_VAL;

    // Request to the shared serial multiplier.
    typedef struct packed {
        logic                     start;
        logic signed [WORK_W-1:0] x;
        logic [GAIN_W-1:0]        y;
    } mul_req_t;

    function automatic logic fa_sum(input logic a, input logic b, input logic c);
        return a ^ b ^ c;
    endfunction

    function automatic logic fa_carry(input logic a, input logic b, input logic c);
        return (a & b) | (a & c) | (b & c);
    endfunction

    // One step of an LSB-first signed compare; the flag ends as a < b.
    function automatic logic cmp_step(input logic lt, input logic a, input logic b,
                                      input logic msb);
        logic r;
        r = lt;
        if (a != b)
        begin
            r = msb ? a : b;
        end
        return r;
    endfunction

    // Bit i of a sign-extended position-width value.
    function automatic logic bit_at(input logic [POS_W-1:0] x, input logic [CNT_W-1:0] i);
        logic r;
        if (i >= CNT_W'(POS_W))
        begin
            r = x[POS_W-1];
        end
        else
        begin
            r = x[i[POS_IDX_W-1:0]];
        end
        return r;
    endfunction

    function automatic logic signed [WORK_W-1:0] sext_work(input logic [POS_W-1:0] v);
        return {{(WORK_W-POS_W){v[POS_W-1]}}, v};
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic [WORK_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if ((v[WORK_W-1:POS_W-1] == '0) || (v[WORK_W-1:POS_W-1] == '1))
        begin
            r = v[POS_W-1:0];
        end
        else if (v[WORK_W-1])
        begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    // -ONE < v < ONE
    function automatic logic is_unit_small(input logic [POS_W-1:0] v);
        return (v[POS_W-1:FRAC_BITS] == '0) ||
               ((v[POS_W-1:FRAC_BITS] == '1) && (v[FRAC_BITS-1:0] != '0));
    endfunction

    // 0 < v < ONE
    function automatic logic is_pos_small(input logic [POS_W-1:0] v);
        return (v[POS_W-1:FRAC_BITS] == '0) && (v[FRAC_BITS-1:0] != '0);
    endfunction

    // -ONE < v < 0
    function automatic logic is_neg_small(input logic [POS_W-1:0] v);
        return (v[POS_W-1:FRAC_BITS] == '1) && (v[FRAC_BITS-1:0] != '0);
    endfunction

endpackage

[src/ksb_serial_mul.sv]
// Serial-parallel multiplier: a signed operand enters one bit per cycle,
// an unsigned 17-bit factor is held, and the product is floored by FRAC_BITS.
// Depends on ksb_pkg.
module ksb_serial_mul
    import ksb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mul_req_t                 req,
    output logic                     done,
    output logic signed [WORK_W-1:0] product
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [WORK_W-1:0]    x_sr_reg;
    logic [GAIN_W-1:0]    y_reg;
    logic [GAIN_W-1:0]    acc_reg;
    logic [WORK_W-1:0]    p_sr_reg;

    logic [GAIN_W:0]      addend;
    logic [GAIN_W:0]      sum;
    logic                 last;

    // The x shift register replicates its sign bit, so the operand is
    // sign-extended for as long as the product needs.
    always_comb
    begin
        addend = x_sr_reg[0] ? {1'b0, y_reg} : '0;
        sum    = {1'b0, acc_reg} + addend;
        last   = (cnt_reg == MUL_CNT_W'(MUL_CYCLES - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Low product bits below the binary point are dropped, which floors.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_sr_reg <= req.x;
            y_reg    <= req.y;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            x_sr_reg <= {x_sr_reg[WORK_W-1], x_sr_reg[WORK_W-1:1]};
            acc_reg  <= sum[GAIN_W:1];
            if (cnt_reg >= MUL_CNT_W'(FRAC_BITS))
            begin
                p_sr_reg <= {sum[0], p_sr_reg[WORK_W-1:1]};
            end
        end
    end

    assign done    = done_reg;
    assign product = p_sr_reg;

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("multiplier reports done while still busy");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && last) |=> (done_reg && !busy_reg))
        else $error("multiplier did not finish after its last cycle");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("multiplier done held for more than one cycle");
`endif

endmodule

[src/kinetic_scroll_bounce_step.sv]
// Top level of the one-axis kinetic scroll step with elastic overshoot.
// Depends on ksb_pkg and ksb_serial_mul.
//
// Each item either loads position and velocity (mode 0) or advances one frame
// (mode 1), and gives one result: position and velocity, both 16.16 fixed
// point, and settled. The arithmetic is bit serial, least significant bit
// first, over 34-bit words, and the two multiplies share one serial-parallel
// multiplier. A load item runs one serial compare pass. A frame item runs a
// serial move pass, a compare pass and one multiply inside the soft limits,
// adds a serial add and compare pass in an overshoot zone, and a second
// multiply when a bounce-back velocity is computed.
// One item is worked at a time; a finished result waits in the output
// register while the next item is accepted. Configuration writes are always
// taken and must only be issued while the block is idle.
module kinetic_scroll_bounce_step
    import ksb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    mode,
    input  logic signed [POS_W-1:0] load_position,
    input  logic signed [POS_W-1:0] load_velocity,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [POS_W-1:0] position,
    output logic signed [POS_W-1:0] velocity,
    output logic                    settled,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [POS_W-1:0]        cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MOVE = 4'd1;
    localparam logic [3:0] S_MSEL = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_MST1 = 4'd4;
    localparam logic [3:0] S_MUL1 = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_BCHK = 4'd7;
    localparam logic [3:0] S_MUL2 = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // Configuration registers.
    logic signed [POS_W-1:0] hard_low_reg;
    logic signed [POS_W-1:0] soft_low_reg;
    logic signed [POS_W-1:0] soft_high_reg;
    logic signed [POS_W-1:0] hard_high_reg;
    logic [GAIN_W-1:0]       normal_decay_reg;
    logic [GAIN_W-1:0]       overshoot_decay_reg;
    logic [GAIN_W-1:0]       bounce_gain_reg;

    // Sequencer and state.
    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    frame_reg, frame_next;
    logic                    below_reg, below_next;
    logic                    above_reg, above_next;
    logic [3:0]              flag_reg, flag_next;
    logic [2:0]              carry_reg, carry_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic signed [POS_W-1:0] vel_reg, vel_next;
    logic signed [POS_W-1:0] step_reg, step_next;
    logic [WORK_W-1:0]       lane_sr_reg [3];
    logic [WORK_W-1:0]       lane_sr_next [3];
    logic                    out_valid_reg, out_valid_next;
    logic signed [POS_W-1:0] out_pos_reg, out_pos_next;
    logic signed [POS_W-1:0] out_vel_reg, out_vel_next;
    logic                    settled_reg, settled_next;

    // Serial lane and comparator signals.
    logic                    pos_b, vel_b, hl_b, sl_b, sh_b, hh_b, soft_b;
    logic                    is_msb;
    logic [2:0]              lane_a, lane_b, lane_s, carry_new;
    logic [3:0]              cmp_a, cmp_b, flag_new;

    // Decision values.
    logic signed [POS_W-1:0]  msel_pos;
    logic signed [WORK_W-1:0] msel_diff;
    logic [GAIN_W-1:0]        rate_sel;
    logic signed [POS_W-1:0]  nv_decay;
    logic signed [POS_W-1:0]  nv_adj;
    logic signed [POS_W-1:0]  nv_bounce;
    logic                     underflow;
    logic                     bounce_need;

    mul_req_t                 mul_req;
    logic                     mul_done;
    logic signed [WORK_W-1:0] mul_product;

    ksb_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_product)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign position  = out_pos_reg;
    assign velocity  = out_vel_reg;
    assign settled   = settled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hard_low_reg        <= HARD_LOW_RST;
            soft_low_reg        <= SOFT_LOW_RST;
            soft_high_reg       <= SOFT_HIGH_RST;
            hard_high_reg       <= HARD_HIGH_RST;
            normal_decay_reg    <= NORMAL_DECAY_RST;
            overshoot_decay_reg <= OVERSHOOT_DECAY_RST;
            bounce_gain_reg     <= BOUNCE_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HARD_LOW:        hard_low_reg        <= cfg_data;
                REG_SOFT_LOW:        soft_low_reg        <= cfg_data;
                REG_SOFT_HIGH:       soft_high_reg       <= cfg_data;
                REG_HARD_HIGH:       hard_high_reg       <= cfg_data;
                REG_NORMAL_DECAY:    normal_decay_reg    <= cfg_data[GAIN_W-1:0];
                REG_OVERSHOOT_DECAY: overshoot_decay_reg <= cfg_data[GAIN_W-1:0];
                REG_BOUNCE_GAIN:     bounce_gain_reg     <= cfg_data[GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Operand bits for the current serial pass.
    always_comb
    begin
        pos_b  = bit_at(pos_reg, cnt_reg);
        vel_b  = bit_at(vel_reg, cnt_reg);
        hl_b   = bit_at(hard_low_reg, cnt_reg);
        sl_b   = bit_at(soft_low_reg, cnt_reg);
        sh_b   = bit_at(soft_high_reg, cnt_reg);
        hh_b   = bit_at(hard_high_reg, cnt_reg);
        soft_b = below_reg ? sl_b : sh_b;
        is_msb = (cnt_reg == CNT_W'(WORK_W - 1));

        lane_a = '0;
        lane_b = '0;
        unique case (state_reg)
            // Lanes: position plus velocity, hard_low minus position,
            // hard_high minus position.
            S_MOVE:
            begin
                lane_a = {hh_b, hl_b, pos_b};
                lane_b = {~pos_b, ~pos_b, vel_b};
            end
            // Lanes: position plus new velocity, soft bound minus position.
            S_SUM:
            begin
                lane_a = {1'b0, soft_b, pos_b};
                lane_b = {1'b0, ~pos_b, vel_b};
            end
            default:
            begin
            end
        endcase

        for (int k = 0; k < 3; k++)
        begin
            lane_s[k]    = fa_sum(lane_a[k], lane_b[k], carry_reg[k]);
            carry_new[k] = fa_carry(lane_a[k], lane_b[k], carry_reg[k]);
        end
    end

    // Comparator inputs; each flag ends as a < b after the sign bit.
    always_comb
    begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (state_reg)
            S_MOVE:
            begin
                cmp_a = {hh_b, sh_b, lane_s[0], lane_s[0]};
                cmp_b = {lane_s[0], lane_s[0], sl_b, hl_b};
            end
            S_CMP:
            begin
                cmp_a[1:0] = {sh_b, pos_b};
                cmp_b[1:0] = {pos_b, sl_b};
            end
            S_SUM:
            begin
                cmp_a[1:0] = {lane_s[0], hl_b};
                cmp_b[1:0] = {hh_b, lane_s[0]};
            end
            default:
            begin
            end
        endcase

        for (int k = 0; k < 4; k++)
        begin
            flag_new[k] = cmp_step(flag_reg[k], cmp_a[k], cmp_b[k], is_msb);
        end
    end

    // Position update after the move pass.
    always_comb
    begin
        priority if (flag_reg[0])
        begin
            msel_pos  = hard_low_reg;
            msel_diff = lane_sr_reg[1];
        end
        else if (flag_reg[1] && is_pos_small(vel_reg))
        begin
            msel_pos  = soft_low_reg;
            msel_diff = '0;
        end
        else if (flag_reg[2] && is_neg_small(vel_reg))
        begin
            msel_pos  = soft_high_reg;
            msel_diff = '0;
        end
        else if (flag_reg[3])
        begin
            msel_pos  = hard_high_reg;
            msel_diff = lane_sr_reg[2];
        end
        else
        begin
            msel_pos  = lane_sr_reg[0][POS_W-1:0];
            msel_diff = sext_work(vel_reg);
        end
    end

    // Velocity decisions after each multiply and after the sum pass.
    always_comb
    begin
        rate_sel  = (below_reg || above_reg) ? overshoot_decay_reg : normal_decay_reg;
        nv_decay  = sat_pos(mul_product);
        underflow = (step_reg != '0) && (rate_sel != '0) && (nv_decay == step_reg);
        if (underflow)
        begin
            nv_adj = step_reg[POS_W-1] ? NEG_ONE_VAL : ONE_VAL;
        end
        else
        begin
            nv_adj = nv_decay;
        end

        // A zero bounce still pushes back toward the soft range.
        nv_bounce = sat_pos(mul_product);
        if (nv_bounce == '0)
        begin
            nv_bounce = below_reg ? ONE_VAL : NEG_ONE_VAL;
        end

        if (below_reg)
        begin
            bounce_need = !flag_reg[0] || (vel_reg == '0) || is_neg_small(vel_reg);
        end
        else
        begin
            bounce_need = !flag_reg[1] || (vel_reg[POS_W-1:FRAC_BITS] == '0);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        frame_next     = frame_reg;
        below_next     = below_reg;
        above_next     = above_reg;
        flag_next      = flag_reg;
        carry_next     = carry_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_vel_next   = out_vel_reg;
        settled_next   = settled_reg;
        for (int k = 0; k < 3; k++)
        begin
            lane_sr_next[k] = lane_sr_reg[k];
        end

        mul_req.start = 1'b0;
        mul_req.x     = sext_work(step_reg);
        mul_req.y     = rate_sel;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Serial passes advance one bit per cycle.
        if ((state_reg == S_MOVE) || (state_reg == S_CMP) || (state_reg == S_SUM))
        begin
            cnt_next   = cnt_reg + 1'b1;
            carry_next = carry_new;
            flag_next  = flag_new;
            for (int k = 0; k < 3; k++)
            begin
                lane_sr_next[k] = {lane_s[k], lane_sr_reg[k][WORK_W-1:1]};
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next   = '0;
                    carry_next = 3'b110;
                    flag_next  = '0;
                    if (!mode)
                    begin
                        pos_next   = load_position;
                        vel_next   = load_velocity;
                        frame_next = 1'b0;
                        state_next = S_CMP;
                    end
                    else
                    begin
                        frame_next = 1'b1;
                        state_next = S_MOVE;
                    end
                end
            end
            S_MOVE:
            begin
                if (is_msb)
                begin
                    state_next = S_MSEL;
                end
            end
            S_MSEL:
            begin
                pos_next   = msel_pos;
                step_next  = sat_pos(msel_diff);
                cnt_next   = '0;
                carry_next = 3'b110;
                flag_next  = '0;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (is_msb)
                begin
                    below_next = flag_new[0];
                    above_next = flag_new[1];
                    state_next = frame_reg ? S_MST1 : S_DONE;
                end
            end
            S_MST1:
            begin
                mul_req.start = 1'b1;
                state_next    = S_MUL1;
            end
            S_MUL1:
            begin
                if (mul_done)
                begin
                    vel_next = nv_adj;
                    if (below_reg || above_reg)
                    begin
                        cnt_next   = '0;
                        carry_next = 3'b110;
                        flag_next  = '0;
                        state_next = S_SUM;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SUM:
            begin
                if (is_msb)
                begin
                    state_next = S_BCHK;
                end
            end
            S_BCHK:
            begin
                if (bounce_need)
                begin
                    mul_req.start = 1'b1;
                    mul_req.x     = lane_sr_reg[1];
                    mul_req.y     = bounce_gain_reg;
                    state_next    = S_MUL2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL2:
            begin
                if (mul_done)
                begin
                    vel_next   = nv_bounce;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg;
                    out_vel_next   = vel_reg;
                    settled_next   = !below_reg && !above_reg && is_unit_small(vel_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            frame_reg     <= 1'b0;
            below_reg     <= 1'b0;
            above_reg     <= 1'b0;
            flag_reg      <= '0;
            carry_reg     <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            frame_reg     <= frame_next;
            below_reg     <= below_next;
            above_reg     <= above_next;
            flag_reg      <= flag_next;
            carry_reg     <= carry_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        out_pos_reg <= out_pos_next;
        out_vel_reg <= out_vel_next;
        settled_reg <= settled_next;
        for (int k = 0; k < 3; k++)
        begin
            lane_sr_reg[k] <= lane_sr_next[k];
        end
    end

`ifndef SYNTH
    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (!out_valid_reg || !out_stall))
        |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("finished item did not reach the output register");

    a_settled_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && settled_reg) |-> is_unit_small(out_vel_reg))
        else $error("settled result carries a velocity of one unit or more");

    a_load_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !mode)
        |=> ((state_reg == S_CMP) && (pos_reg == $past(load_position))))
        else $error("load item not taken into the position register");

    a_mul_start_place: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> ((state_reg == S_MST1) || (state_reg == S_BCHK)))
        else $error("multiplier started outside a multiply step");
`endif

endmodule

[bench/kinetic_scroll_bounce_step_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for kinetic_scroll_bounce_step: mirrors the registers and the scroll state,
// predicts each result and compares it with the block's output. Depends on ksb_pkg.
package scroll_bench_pkg;

    typedef enum logic
    {
        ITEM_LOAD  = 1'b0,
        ITEM_FRAME = 1'b1
    } item_kind_t;

endpackage

module kinetic_scroll_bounce_step_checker
    import ksb_pkg::*;
    import scroll_bench_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    mode,
    input  logic signed [POS_W-1:0] load_position,
    input  logic signed [POS_W-1:0] load_velocity,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [POS_W-1:0] position,
    input  logic signed [POS_W-1:0] velocity,
    input  logic                    settled,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [POS_W-1:0]        cfg_data,
    output int                      fail_count,
    output int                      pending
);

    localparam longint FX_ONE   = longint'(1) << FRAC_BITS;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct packed
    {
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] velocity;
        logic                    settled;
    } scroll_result_t;

    longint bound_hard_low;
    longint bound_soft_low;
    longint bound_soft_high;
    longint bound_hard_high;
    longint rate_normal;
    longint rate_overshoot;
    longint bounce_gain;
    longint track_position;
    longint track_velocity;

    scroll_result_t scroll_results_q[$];
    scroll_result_t want;
    scroll_result_t got;

    function automatic longint clip_word(input longint v);
        longint r;
        r = v;
        if (v > WORD_MAX)
        begin
            r = WORD_MAX;
        end
        else if (v < WORD_MIN)
        begin
            r = WORD_MIN;
        end
        return r;
    endfunction

    // Arithmetic shift of the exact product rounds toward minus infinity.
    function automatic longint scale_fx(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic void advance_frame();
        longint pos;
        longint step;
        longint target;
        longint rate;
        longint nv;
        logic   below;
        logic   above;
        pos = track_position;
        step = track_velocity;
        target = pos + step;
        if (target < bound_hard_low)
        begin
            step = bound_hard_low - pos;
            target = bound_hard_low;
        end
        else if (target < bound_soft_low && step > 0 && step < FX_ONE)
        begin
            step = 0;
            target = bound_soft_low;
        end
        else if (target > bound_soft_high && step > -FX_ONE && step < 0)
        begin
            step = 0;
            target = bound_soft_high;
        end
        else if (target > bound_hard_high)
        begin
            step = bound_hard_high - pos;
            target = bound_hard_high;
        end
        track_position = target;
        step = clip_word(step);

        below = target < bound_soft_low;
        above = target > bound_soft_high;
        rate = (below || above) ? rate_overshoot : rate_normal;
        nv = clip_word(scale_fx(step, rate));
        // A product that rounds back to the step itself still moves one unit.
        if (step != 0 && rate != 0 && nv == step)
        begin
            nv = (step < 0) ? -FX_ONE : FX_ONE;
        end
        if (below)
        begin
            if ((target + nv <= bound_hard_low) || (nv > -FX_ONE && nv <= 0))
            begin
                nv = clip_word(scale_fx(bound_soft_low - target, bounce_gain));
                if (nv == 0)
                begin
                    nv = FX_ONE;
                end
            end
        end
        else if (above)
        begin
            if ((target + nv >= bound_hard_high) || (nv >= 0 && nv < FX_ONE))
            begin
                nv = clip_word(scale_fx(bound_soft_high - target, bounce_gain));
                if (nv == 0)
                begin
                    nv = -FX_ONE;
                end
            end
        end
        track_velocity = nv;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_hard_low  = longint'(HARD_LOW_RST);
            bound_soft_low  = longint'(SOFT_LOW_RST);
            bound_soft_high = longint'(SOFT_HIGH_RST);
            bound_hard_high = longint'(HARD_HIGH_RST);
            rate_normal     = longint'(NORMAL_DECAY_RST);
            rate_overshoot  = longint'(OVERSHOOT_DECAY_RST);
            bounce_gain     = longint'(BOUNCE_GAIN_RST);
            track_position  = 0;
            track_velocity  = 0;
            fail_count      = 0;
            scroll_results_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HARD_LOW:        bound_hard_low  = longint'($signed(cfg_data));
                    REG_SOFT_LOW:        bound_soft_low  = longint'($signed(cfg_data));
                    REG_SOFT_HIGH:       bound_soft_high = longint'($signed(cfg_data));
                    REG_HARD_HIGH:       bound_hard_high = longint'($signed(cfg_data));
                    REG_NORMAL_DECAY:    rate_normal     = longint'(cfg_data[GAIN_W-1:0]);
                    REG_OVERSHOOT_DECAY: rate_overshoot  = longint'(cfg_data[GAIN_W-1:0]);
                    REG_BOUNCE_GAIN:     bounce_gain     = longint'(cfg_data[GAIN_W-1:0]);
                    default: ;
                endcase
            end

            // Results are matched before the new item is queued, so a result
            // never pairs with an item accepted on the same edge.
            if (out_valid && !out_stall)
            begin
                got.position = position;
                got.velocity = velocity;
                got.settled  = settled;
                if (scroll_results_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: result with none outstanding: pos %0d vel %0d settled %0b",
                                 $realtime, got.position, got.velocity, got.settled);
                    end
                end
                else
                begin
                    want = scroll_results_q.pop_front();
                    if (got.position !== want.position || got.velocity !== want.velocity ||
                        got.settled !== want.settled)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch: expected pos %0d vel %0d settled %0b, got pos %0d vel %0d settled %0b",
                                     $realtime, want.position, want.velocity, want.settled,
                                     got.position, got.velocity, got.settled);
                        end
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (mode == ITEM_LOAD)
                begin
                    track_position = longint'(load_position);
                    track_velocity = longint'(load_velocity);
                end
                else
                begin
                    advance_frame();
                end
                want.position = POS_W'(track_position);
                want.velocity = POS_W'(track_velocity);
                want.settled  = (track_position >= bound_soft_low) &&
                                (track_position <= bound_soft_high) &&
                                (track_velocity > -FX_ONE) && (track_velocity < FX_ONE);
                scroll_results_q.push_back(want);
            end
        end
        pending = scroll_results_q.size();
    end

endmodule

[bench/kinetic_scroll_bounce_step_tb.sv]
`timescale 1ns / 1ps
// Top of the kinetic_scroll_bounce_step bench: clock, reset, register settings and item
// stimulus with random idling. Depends on ksb_pkg and kinetic_scroll_bounce_step_checker.
module kinetic_scroll_bounce_step_tb;
    import ksb_pkg::*;
    import scroll_bench_pkg::*;

    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 250;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int FX_ONE          = 1 << FRAC_BITS;
    localparam logic signed [POS_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef enum int
    {
        SET_TYPICAL,
        SET_WIDE,
        SET_COLLAPSED,
        SET_SCRAMBLED,
        SET_TIGHT
    } setting_t;

    setting_t phase_plan [RANDOM_PHASES] =
        '{SET_TYPICAL, SET_WIDE, SET_SCRAMBLED, SET_COLLAPSED, SET_TIGHT, SET_TYPICAL};

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    mode;
    logic signed [POS_W-1:0] load_position;
    logic signed [POS_W-1:0] load_velocity;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] velocity;
    logic                    settled;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [POS_W-1:0]        cfg_data;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    logic calm = 1'b0;

    // Current bounds, kept only to aim positions at the interesting regions.
    logic signed [POS_W-1:0] lim_hard_low;
    logic signed [POS_W-1:0] lim_soft_low;
    logic signed [POS_W-1:0] lim_soft_high;
    logic signed [POS_W-1:0] lim_hard_high;

    kinetic_scroll_bounce_step dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .load_position (load_position),
        .load_velocity (load_velocity),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position      (position),
        .velocity      (velocity),
        .settled       (settled),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    kinetic_scroll_bounce_step_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .load_position (load_position),
        .load_velocity (load_velocity),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position      (position),
        .velocity      (velocity),
        .settled       (settled),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** kinetic_scroll_bounce_step: FAILED **");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 4);
        end
        else if (r < 97)
        begin
            return $urandom_range(5, 30);
        end
        return $urandom_range(60, 250);
    endfunction

    initial
    begin
        int run;
        out_stall = 1'b0;
        forever
        begin
            run = calm ? 1 : $urandom_range(1, 30);
            repeat (run) @(negedge clk);
            run = calm ? 0 : idle_length();
            if (run > 0)
            begin
                out_stall <= 1'b1;
                repeat (run) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [POS_W-1:0] pick_position();
        int               spread;
        logic [POS_W-1:0] base;
        spread = 20 * FX_ONE;
        case ($urandom_range(0, 9))
            0: base = lim_soft_low;
            1: base = lim_soft_high;
            2: base = lim_hard_low;
            3: base = lim_hard_high;
            4, 5: base = lim_soft_low + ((lim_soft_high - lim_soft_low) >>> 1);
            6: return lim_soft_low + $urandom_range(0, 2 * FX_ONE) - FX_ONE;
            default: return $urandom;
        endcase
        return base + $urandom_range(0, 2 * spread) - spread;
    endfunction

    function automatic logic [POS_W-1:0] pick_velocity(input bit tame);
        logic [POS_W-1:0] mag;
        case (tame ? $urandom_range(0, 5) : $urandom_range(0, 9))
            0: return '0;
            1: mag = $urandom_range(1, FX_ONE - 1);
            2, 3, 4: mag = $urandom & ((32'd1 << $urandom_range(16, 26)) - 32'd1);
            5: mag = $urandom_range(0, 30 * FX_ONE);
            6:
            begin
                case ($urandom_range(0, 3))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return '1;
                    default: return 32'd1;
                endcase
            end
            default: return $urandom;
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Gain registers are 17 bits wide; the bits above them carry noise.
    function automatic logic [POS_W-1:0] gain_word(input logic [GAIN_W-1:0] g);
        logic [POS_W-1:0] w;
        w = $urandom;
        w[GAIN_W-1:0] = g;
        return w;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [POS_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input item_kind_t kind, input logic [POS_W-1:0] pos,
                             input logic [POS_W-1:0] vel);
        int gap;
        gap = calm ? 0 : idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= kind;
        load_position <= pos;
        load_velocity <= vel;
        do @(posedge clk); while (in_stall);
    endtask

    // Drops valid and waits until every outstanding result has been taken.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic apply_setting(input setting_t kind);
        logic [GAIN_W-1:0] nd;
        logic [GAIN_W-1:0] od;
        logic [GAIN_W-1:0] bg;
        nd = GAIN_W'($urandom_range(0, FX_ONE));
        od = GAIN_W'($urandom_range(0, FX_ONE));
        bg = GAIN_W'($urandom_range(0, FX_ONE));
        case (kind)
            SET_TYPICAL:
            begin
                lim_soft_low  = $urandom_range(0, 200 * FX_ONE) - 100 * FX_ONE;
                lim_soft_high = lim_soft_low + $urandom_range(FX_ONE, 2000 * FX_ONE);
                lim_hard_low  = lim_soft_low - $urandom_range(0, 60 * FX_ONE);
                lim_hard_high = lim_soft_high + $urandom_range(0, 60 * FX_ONE);
            end
            SET_WIDE:
            begin
                lim_hard_low  = WORD_MIN;
                lim_soft_low  = -100 * FX_ONE;
                lim_soft_high = 100 * FX_ONE;
                lim_hard_high = WORD_MAX;
                nd = GAIN_W'(FX_ONE);
                od = '0;
                bg = GAIN_W'(FX_ONE);
            end
            SET_COLLAPSED:
            begin
                lim_hard_low  = '0;
                lim_soft_low  = '0;
                lim_soft_high = '0;
                lim_hard_high = '0;
                nd = '0;
                od = GAIN_W'(FX_ONE);
                bg = '0;
            end
            SET_SCRAMBLED:
            begin
                lim_hard_low  = $urandom;
                lim_soft_low  = $urandom;
                lim_soft_high = $urandom;
                lim_hard_high = $urandom;
            end
            default:
            begin
                lim_hard_low  = -8 * FX_ONE;
                lim_soft_low  = '0;
                lim_soft_high = 4 * FX_ONE;
                lim_hard_high = 12 * FX_ONE;
            end
        endcase
        write_reg(REG_HARD_LOW, lim_hard_low);
        write_reg(REG_SOFT_LOW, lim_soft_low);
        write_reg(REG_SOFT_HIGH, lim_soft_high);
        write_reg(REG_HARD_HIGH, lim_hard_high);
        write_reg(REG_NORMAL_DECAY, gain_word(nd));
        write_reg(REG_OVERSHOOT_DECAY, gain_word(od));
        write_reg(REG_BOUNCE_GAIN, gain_word(bg));
    endtask

    initial
    begin
        int sent;
        int frames;
        int pick;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = ITEM_LOAD;
        load_position = '0;
        load_velocity = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        lim_hard_low  = HARD_LOW_RST;
        lim_soft_low  = SOFT_LOW_RST;
        lim_soft_high = SOFT_HIGH_RST;
        lim_hard_high = HARD_HIGH_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset register values.
        send_item(ITEM_LOAD, 0, 0);
        send_item(ITEM_FRAME, 0, 0);
        send_item(ITEM_LOAD, 500 * FX_ONE, 10 * FX_ONE);
        send_item(ITEM_FRAME, '1, '1);
        send_item(ITEM_FRAME, 0, 0);
        // A velocity of minus one fraction unit rounds back to itself.
        send_item(ITEM_LOAD, 500 * FX_ONE, -1);
        send_item(ITEM_FRAME, 0, 0);
        send_item(ITEM_LOAD, 500 * FX_ONE, WORD_MAX);
        send_item(ITEM_FRAME, 0, 0);
        send_item(ITEM_LOAD, 500 * FX_ONE, WORD_MIN);
        send_item(ITEM_FRAME, 0, 0);
        // Slow exits from the overshoot zones snap to the soft bounds.
        send_item(ITEM_LOAD, -10 * FX_ONE, FX_ONE / 2);
        send_item(ITEM_FRAME, 0, 0);
        send_item(ITEM_LOAD, 1010 * FX_ONE, -(FX_ONE / 2));
        send_item(ITEM_FRAME, 0, 0);
        send_item(ITEM_LOAD, -10 * FX_ONE, 0);
        send_item(ITEM_FRAME, 0, 0);
        send_item(ITEM_LOAD, 1010 * FX_ONE, 0);
        send_item(ITEM_FRAME, 0, 0);
        // The bounce product of a tiny overshoot is zero.
        send_item(ITEM_LOAD, -1, 0);
        send_item(ITEM_FRAME, 0, 0);
        send_item(ITEM_LOAD, WORD_MIN, WORD_MIN);
        send_item(ITEM_FRAME, 0, 0);
        send_item(ITEM_LOAD, WORD_MAX, WORD_MAX);
        send_item(ITEM_FRAME, 0, 0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            apply_setting(phase_plan[p]);
            calm = (phase_plan[p] == SET_TIGHT);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    // A load followed by a run of frames follows one trajectory.
                    frames = $urandom_range(3, 25);
                    send_item(ITEM_LOAD, pick_position(), pick_velocity(1'b1));
                    repeat (frames) send_item(ITEM_FRAME, $urandom, $urandom);
                    sent += frames + 1;
                end
                else if (pick < 9)
                begin
                    send_item(ITEM_FRAME, $urandom, $urandom);
                    sent++;
                end
                else
                begin
                    send_item(ITEM_LOAD, pick_position(), pick_velocity(1'b0));
                    sent++;
                end
            end
        end
        calm = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("** kinetic_scroll_bounce_step: PASSED **");
        end
        else
        begin
            $display("** kinetic_scroll_bounce_step: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
src/ksb_pkg.sv
src/ksb_serial_mul.sv
src/kinetic_scroll_bounce_step.sv
bench/kinetic_scroll_bounce_step_checker.sv
bench/kinetic_scroll_bounce_step_tb.sv
